@@ sv/ebp_pkg.sv @@
// Types, codes and the per-bit step function of the message field parser.
package ebp_pkg;

    localparam int KEY_ID_BYTES_DEF = 16;
    localparam int MAX_RES          = 4;

    typedef logic [2:0] t_rcnt;

    typedef enum logic [4:0] {
        PH_NSTATES  = 5'd0,
        PH_NEXTFLAG = 5'd1,
        PH_RESHDR   = 5'd2,
        PH_IVSIZE   = 5'd3,
        PH_DEFKEY   = 5'd4,
        PH_SCR      = 5'd5,
        PH_NAU      = 5'd6,
        PH_KFLAG    = 5'd7,
        PH_RESAU    = 5'd8,
        PH_OFFSZ    = 5'd9,
        PH_KEY      = 5'd10,
        PH_OFF      = 5'd11,
        PH_IV       = 5'd12,
        PH_CD       = 5'd13,
        PH_RESCD    = 5'd14,
        PH_NKEY     = 5'd15,
        PH_SKIP     = 5'd16,
        PH_DONE     = 5'd17,
        PH_EXTRA    = 5'd18
    } t_phase;

    localparam logic [3:0] KIND_NSTATES  = 4'd0;
    localparam logic [3:0] KIND_NEXTFLAG = 4'd1;
    localparam logic [3:0] KIND_IVSIZE   = 4'd2;
    localparam logic [3:0] KIND_DEFKEY   = 4'd3;
    localparam logic [3:0] KIND_SCR      = 4'd4;
    localparam logic [3:0] KIND_NAU      = 4'd5;
    localparam logic [3:0] KIND_KFLAG    = 4'd6;
    localparam logic [3:0] KIND_OFFSZ    = 4'd7;
    localparam logic [3:0] KIND_KEY      = 4'd8;
    localparam logic [3:0] KIND_OFF      = 4'd9;
    localparam logic [3:0] KIND_IV       = 4'd10;
    localparam logic [3:0] KIND_CD       = 4'd11;
    localparam logic [3:0] KIND_NKEY     = 4'd12;
    localparam logic [3:0] KIND_STATUS   = 4'd13;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_TRUNC = 2'd1;
    localparam logic [1:0] STAT_TRAIL = 2'd2;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] acc;
        logic [3:0] need;
        logic [1:0] st_tot;
        logic [1:0] st_cnt;
        logic [5:0] un_tot;
        logic [5:0] un_cnt;
        logic [7:0] by_cnt;
        logic [7:0] iv_len;
        logic [3:0] off_len;
        logic       un_key;
        logic       nk_key;
    } t_pstate;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic [1:0] st;
        logic [5:0] un;
        logic [7:0] by;
        logic [1:0] status;
        logic       last;
    } t_field;

    typedef struct packed {
        t_pstate s;
        logic    fv;
        t_field  f;
    } t_step;

    typedef struct packed {
        t_field [MAX_RES-1:0] slot;
        t_rcnt                cnt;
    } t_batch;

    typedef struct packed {
        logic  can_load;
        t_rcnt left;
    } t_qstat;

    function automatic t_pstate reset_state();
        t_pstate s;
        s        = '0;
        s.phase  = PH_NSTATES;
        s.need   = 4'd2;
        return s;
    endfunction

    function automatic t_pstate enter(t_pstate s, t_phase ph, logic [3:0] w);
        s.phase = ph;
        s.need  = w;
        s.acc   = '0;
        return s;
    endfunction

    function automatic t_pstate begin_tail(t_pstate s);
        if (s.nk_key) return enter(s, PH_CD, 4'd4);
        return enter(s, PH_SKIP, 4'd2);
    endfunction

    function automatic t_pstate begin_state(t_pstate s);
        if (s.st_cnt < s.st_tot) return enter(s, PH_SCR, 4'd2);
        return begin_tail(s);
    endfunction

    function automatic t_pstate begin_unit(t_pstate s);
        if (s.un_cnt < s.un_tot) return enter(s, PH_KFLAG, 4'd1);
        s.st_cnt = s.st_cnt + 2'd1;
        return begin_state(s);
    endfunction

    function automatic t_pstate end_unit(t_pstate s);
        s.un_cnt = s.un_cnt + 6'd1;
        return begin_unit(s);
    endfunction

    function automatic t_pstate begin_iv(t_pstate s);
        s.by_cnt = '0;
        if (s.iv_len != 8'd0) return enter(s, PH_IV, 4'd8);
        return end_unit(s);
    endfunction

    function automatic t_pstate begin_off(t_pstate s);
        s.by_cnt = '0;
        if (s.off_len != 4'd0) return enter(s, PH_OFF, 4'd8);
        return begin_iv(s);
    endfunction

    function automatic t_field mk_field(logic [3:0] kind, logic [7:0] value,
                                        logic [1:0] st, logic [5:0] un,
                                        logic [7:0] by);
        t_field f;
        f        = '0;
        f.kind   = kind;
        f.value  = value;
        f.st     = st;
        f.un     = un;
        f.by     = by;
        return f;
    endfunction

    // One message bit; at most one field completes per bit.
    function automatic t_step bit_step(t_pstate s, logic b, logic [8:0] key_lim);
        t_step      r;
        logic [7:0] v;
        logic [8:0] nxt;
        r.fv = 1'b0;
        r.f  = '0;
        v    = '0;
        nxt  = '0;
        if (s.phase >= PH_DONE) begin
            s.phase = PH_EXTRA;
        end else begin
            s.acc = {s.acc[6:0], b};
            if (s.need != 4'd0) s.need = s.need - 4'd1;
            if (s.need == 4'd0) begin
                v   = s.acc;
                nxt = {1'b0, s.by_cnt} + 9'd1;
                unique case (s.phase)
                    PH_NSTATES: begin
                        s.st_tot = v[1:0];
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_NSTATES, v, '0, '0, '0);
                        s    = enter(s, PH_NEXTFLAG, 4'd1);
                    end
                    PH_NEXTFLAG: begin
                        s.nk_key = v[0];
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_NEXTFLAG, v, '0, '0, '0);
                        s    = enter(s, PH_RESHDR, 4'd3);
                    end
                    PH_RESHDR: s = enter(s, PH_IVSIZE, 4'd8);
                    PH_IVSIZE: begin
                        s.iv_len = v;
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_IVSIZE, v, '0, '0, '0);
                        s.by_cnt = '0;
                        s    = enter(s, PH_DEFKEY, 4'd8);
                    end
                    PH_DEFKEY: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_DEFKEY, v, '0, '0, s.by_cnt);
                        if (nxt >= key_lim) begin
                            s.by_cnt = '0;
                            s.st_cnt = '0;
                            s = begin_state(s);
                        end else begin
                            s.by_cnt = nxt[7:0];
                            s = enter(s, PH_DEFKEY, 4'd8);
                        end
                    end
                    PH_SCR: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_SCR, v, s.st_cnt, '0, '0);
                        s    = enter(s, PH_NAU, 4'd6);
                    end
                    PH_NAU: begin
                        s.un_tot = v[5:0];
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_NAU, v, s.st_cnt, '0, '0);
                        s.un_cnt = '0;
                        s = begin_unit(s);
                    end
                    PH_KFLAG: begin
                        s.un_key = v[0];
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_KFLAG, v, s.st_cnt, s.un_cnt, '0);
                        s    = enter(s, PH_RESAU, 4'd3);
                    end
                    PH_RESAU: s = enter(s, PH_OFFSZ, 4'd4);
                    PH_OFFSZ: begin
                        s.off_len = v[3:0];
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_OFFSZ, v, s.st_cnt, s.un_cnt, '0);
                        s.by_cnt = '0;
                        if (s.un_key) s = enter(s, PH_KEY, 4'd8);
                        else          s = begin_off(s);
                    end
                    PH_KEY: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_KEY, v, s.st_cnt, s.un_cnt, s.by_cnt);
                        if (nxt >= key_lim) begin
                            s = begin_off(s);
                        end else begin
                            s.by_cnt = nxt[7:0];
                            s = enter(s, PH_KEY, 4'd8);
                        end
                    end
                    PH_OFF: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_OFF, v, s.st_cnt, s.un_cnt, s.by_cnt);
                        if (nxt >= {5'd0, s.off_len}) begin
                            s = begin_iv(s);
                        end else begin
                            s.by_cnt = nxt[7:0];
                            s = enter(s, PH_OFF, 4'd8);
                        end
                    end
                    PH_IV: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_IV, v, s.st_cnt, s.un_cnt, s.by_cnt);
                        if (nxt >= {1'b0, s.iv_len}) begin
                            s.by_cnt = '0;
                            s = end_unit(s);
                        end else begin
                            s.by_cnt = nxt[7:0];
                            s = enter(s, PH_IV, 4'd8);
                        end
                    end
                    PH_CD: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_CD, v, '0, '0, '0);
                        s    = enter(s, PH_RESCD, 4'd4);
                    end
                    PH_RESCD: begin
                        s.by_cnt = '0;
                        s = enter(s, PH_NKEY, 4'd8);
                    end
                    PH_NKEY: begin
                        r.fv = 1'b1;
                        r.f  = mk_field(KIND_NKEY, v, '0, '0, s.by_cnt);
                        if (nxt >= key_lim) begin
                            s.by_cnt = '0;
                            s = enter(s, PH_SKIP, 4'd2);
                        end else begin
                            s.by_cnt = nxt[7:0];
                            s = enter(s, PH_NKEY, 4'd8);
                        end
                    end
                    PH_SKIP: begin
                        s.phase = PH_DONE;
                        s.need  = '0;
                        s.acc   = '0;
                    end
                    default: s.phase = PH_EXTRA;
                endcase
            end
        end
        r.s = s;
        return r;
    endfunction

endpackage

@@ sv/ecm_bitfield_parser_core.sv @@
// Top level of the encryption control message field parser.
//
// Input channel: one message word (i_data_byte) per handshake on i_valid /
// o_ready, bits taken most significant first; i_final_byte marks the last
// word of a message. Output channel: one completed field per handshake on
// o_valid / i_ready, with kind, value, state, unit and byte indices. The
// final word adds a status item (ok, truncated, trailing data), and
// o_last_result marks the last item that a word gives.
// A word accepted into the input register is parsed there combinationally;
// its items are then loaded into the result register, which drives the outputs.
// Throughput: one word per cycle while each word gives at most one item and
// the receiver is ready; a word giving more items holds the input side while
// the single result register drains them one item a cycle while i_ready is high.
// The next word is taken while the last item of the previous one waits.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a message; so does the end of a final word.
// A stalled receiver holds the current item steady; once the result
// register and input register are both full, o_ready drops.
module ecm_bitfield_parser_core #(
    parameter int KeyIdBytes = ebp_pkg::KEY_ID_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_field_kind,
    output logic [7:0] o_field_value,
    output logic [1:0] o_state_number,
    output logic [5:0] o_unit_number,
    output logic [7:0] o_byte_number,
    output logic [1:0] o_parse_status,
    output logic       o_last_result
);
    import ebp_pkg::*;

    logic   w_load;
    t_batch w_batch;
    t_qstat w_qstat;
    t_field w_field;

    ebp_parse_stage #(
        .KeyIdBytes(KeyIdBytes)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_final_byte(i_final_byte),
        .i_can_load  (w_qstat.can_load),
        .o_load      (w_load),
        .o_batch     (w_batch)
    );

    ebp_result_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_batch(w_batch),
        .o_stat (w_qstat),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_field(w_field)
    );

    assign o_field_kind   = w_field.kind;
    assign o_field_value  = w_field.value;
    assign o_state_number = w_field.st;
    assign o_unit_number  = w_field.un;
    assign o_byte_number  = w_field.by;
    assign o_parse_status = w_field.status;
    assign o_last_result  = w_field.last;

    a_batch_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (w_batch.cnt <= t_rcnt'(3)))
        else $error("word gave more than three items");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_result) |-> (w_qstat.left == t_rcnt'(1)))
        else $error("last item of a word left others queued");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_field_kind == KIND_STATUS) |-> o_last_result)
        else $error("status item not last of its word");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_valid || (i_ready && w_qstat.left == t_rcnt'(1))))
        else $error("result register overwritten");

endmodule

@@ sv/ebp_parse_stage.sv @@
// Input word register, parser state and the per-word field extraction.
module ebp_parse_stage #(
    parameter int KeyIdBytes = ebp_pkg::KEY_ID_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_final_byte,
    input  logic            i_can_load,
    output logic            o_load,
    output ebp_pkg::t_batch o_batch
);
    import ebp_pkg::*;

    localparam logic [8:0] KeyLim = 9'(KeyIdBytes);

    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_final;
    t_pstate    r_ps;
    t_pstate    n_ps;

    t_pstate    ps;
    t_step      stp;
    t_rcnt      cnt;
    t_batch     batch;
    logic       take;

    assign take    = r_in_vld & i_can_load;
    assign o_ready = ~r_in_vld | i_can_load;
    assign o_load  = take;
    assign o_batch = batch;

    always_comb begin
        ps    = r_ps;
        stp   = '0;
        cnt   = '0;
        batch = '0;
        for (int i = 7; i >= 0; i--) begin
            stp = bit_step(ps, r_byte[i], KeyLim);
            ps  = stp.s;
            if (stp.fv && cnt < t_rcnt'(MAX_RES)) begin
                for (int j = 0; j < MAX_RES; j++) begin
                    if (cnt == t_rcnt'(j)) batch.slot[j] = stp.f;
                end
                cnt = cnt + t_rcnt'(1);
            end
        end
        if (r_final) begin
            if (cnt < t_rcnt'(MAX_RES)) begin
                for (int j = 0; j < MAX_RES; j++) begin
                    if (cnt == t_rcnt'(j)) begin
                        batch.slot[j]      = mk_field(KIND_STATUS, '0, '0, '0, '0);
                        batch.slot[j].status = (ps.phase == PH_DONE)  ? STAT_OK :
                                               (ps.phase == PH_EXTRA) ? STAT_TRAIL :
                                                                        STAT_TRUNC;
                    end
                end
                cnt = cnt + t_rcnt'(1);
            end
            ps = reset_state();
        end
        for (int j = 0; j < MAX_RES; j++) begin
            if (cnt == t_rcnt'(j + 1)) batch.slot[j].last = 1'b1;
        end
        batch.cnt = cnt;
        n_ps      = ps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_ps     <= reset_state();
        end else begin
            if (o_ready) r_in_vld <= i_valid;
            if (take)    r_ps     <= n_ps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_data_byte;
            r_final <= i_final_byte;
        end
    end

endmodule

@@ sv/ebp_result_queue.sv @@
// Result register: holds the fields of one word and hands them out one a cycle while i_ready is high.
module ebp_result_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ebp_pkg::t_batch i_batch,
    output ebp_pkg::t_qstat o_stat,
    output logic            o_valid,
    input  logic            i_ready,
    output ebp_pkg::t_field o_field
);
    import ebp_pkg::*;

    t_field [MAX_RES-1:0] r_slot;
    t_rcnt                r_left;
    logic                 pop;

    assign o_valid         = (r_left != '0);
    assign pop             = o_valid & i_ready;
    assign o_field         = r_slot[0];
    assign o_stat.left     = r_left;
    assign o_stat.can_load = (r_left == '0) | ((r_left == t_rcnt'(1)) & pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_batch.cnt;
        end else if (pop) begin
            r_left <= r_left - t_rcnt'(1);
        end
    end

    // head is always slot 0; pop shifts the rest down
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_batch.slot;
        end else if (pop) begin
            for (int j = 0; j < MAX_RES - 1; j++) r_slot[j] <= r_slot[j + 1];
        end
    end

endmodule
